FILE: rtl/core/pla_pkg.sv
// Package for the process level alarm block.
// Types, constants and codes shared by the alarm core and record store.
`timescale 1ns / 1ps
package pla_pkg;
  localparam int RecDepth = 16;
  localparam int RecAw = 4;
  localparam int ValueBits = 24;
  localparam int CntBits = 5;

  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_ACK_ONE = 2'd1;
  localparam logic [1:0] CMD_ACK_ALL = 2'd2;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_TRIG = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_ACK = 2'd3;

  localparam logic [2:0] REG_POINT = 3'd0;
  localparam logic [2:0] REG_ENABLE = 3'd1;
  localparam logic [2:0] REG_HH = 3'd2;
  localparam logic [2:0] REG_H = 3'd3;
  localparam logic [2:0] REG_L = 3'd4;
  localparam logic [2:0] REG_LL = 3'd5;
  localparam logic [2:0] REG_HYST = 3'd6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] point_id;
    logic signed [ValueBits-1:0] sample;
    logic [15:0] ack_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] alarm_level;
    logic [15:0] record_id;
    logic signed [ValueBits-1:0] value;
    logic [CntBits-1:0] active_count;
    logic [CntBits-1:0] unacked_count;
    logic overflow;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] level;
    logic [15:0] ident;
    logic signed [ValueBits-1:0] value;
  } rec_data_t;
endpackage

FILE: rtl/core/process_level_alarm_with_ack.sv
// Top level of the process level alarm: configuration registers and core.
// Depends on pla_pkg and pla_core.
// Busy is not raised for an ignored word; a new word is taken only while idle.
// Acknowledges and each acting level of an evaluate sweep the record memory.
// Synchronous active-low reset loads configuration defaults and clears record
// flags; results cannot stall.
`timescale 1ns / 1ps
module process_level_alarm_with_ack
  import pla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             in_word,
  output logic                 out_strobe,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [ValueBits-1:0] cfg_data
);
  logic [7:0] point_r;
  logic [3:0] enable_r;
  logic [ValueBits-1:0] hh_r, h_r, l_r, ll_r;
  logic [9:0] hyst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
      enable_r <= '0;
      hh_r <= {1'b0, {(ValueBits-1){1'b1}}};
      h_r <= {1'b0, {(ValueBits-1){1'b1}}};
      l_r <= {1'b1, {(ValueBits-1){1'b0}}};
      ll_r <= {1'b1, {(ValueBits-1){1'b0}}};
      hyst_r <= 10'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POINT: point_r <= cfg_data[7:0];
        REG_ENABLE: enable_r <= cfg_data[3:0];
        REG_HH: hh_r <= cfg_data;
        REG_H: h_r <= cfg_data;
        REG_L: l_r <= cfg_data;
        REG_LL: ll_r <= cfg_data;
        REG_HYST: hyst_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  pla_core u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .watched_point(point_r), .level_enable(enable_r), .lim_hh(hh_r), .lim_h(h_r),
    .lim_l(l_r), .lim_ll(ll_r), .hyst(hyst_r), .out_valid(out_strobe),
    .out_word(out_word)
  );
endmodule

FILE: rtl/core/pla_rec_mem.sv
// Record payload memory: level, id and value, one write and one read port.
// Depends on pla_pkg.
`timescale 1ns / 1ps
module pla_rec_mem
  import pla_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [RecAw-1:0] waddr,
  input  rec_data_t        wdata,
  input  logic [RecAw-1:0] raddr,
  output rec_data_t        rdata
);
  rec_data_t mem [RecDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/pla_core.sv
// Alarm sequencer: level checks, record table flags, compaction and results.
// Depends on pla_pkg and pla_rec_mem.
`timescale 1ns / 1ps
module pla_core
  import pla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_word_t             in_word,
  output logic                 busy,
  input  logic [7:0]           watched_point,
  input  logic [3:0]           level_enable,
  input  logic [ValueBits-1:0] lim_hh,
  input  logic [ValueBits-1:0] lim_h,
  input  logic [ValueBits-1:0] lim_l,
  input  logic [ValueBits-1:0] lim_ll,
  input  logic [9:0]           hyst,
  output logic                 out_valid,
  output out_word_t            out_word
);
  typedef enum logic [3:0] {
    S_IDLE, S_LEVEL, S_MUL, S_CMP, S_CPREAD, S_CPWRITE, S_FIRE,
    S_SCAN_RD, S_SCAN_EMIT, S_SUMMARY
  } state_t;

  state_t state_r;
  in_word_t in_r;
  logic [1:0] lvl_r;
  logic [3:0] level_active_r;
  logic [RecDepth-1:0] used_r, active_r, acked_r;
  logic [15:0] next_ident_r;
  logic [CntBits-1:0] active_total_r, unacked_total_r;
  logic [RecAw-1:0] idx_r, dst_r;
  logic [1:0] scan_mode_r;
  logic ack_hit_r;
  logic [4:0] fill_r;
  logic signed [ValueBits+10:0] lhs_r, rhs_r;
  logic lim_gt_r, lim_lt_r;
  logic pend_r, pend_ovf_r;

  localparam logic [1:0] SCAN_CLEAR = 2'd0;
  localparam logic [1:0] SCAN_ACK1 = 2'd1;
  localparam logic [1:0] SCAN_ACKALL = 2'd2;

  logic mem_we;
  logic [RecAw-1:0] mem_waddr, mem_raddr;
  rec_data_t mem_wdata, mem_rdata;

  pla_rec_mem u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic signed [ValueBits-1:0] lim_sel;
  always_comb begin
    unique case (lvl_r)
      2'd0: lim_sel = lim_hh;
      2'd1: lim_sel = lim_h;
      2'd2: lim_sel = lim_l;
      default: lim_sel = lim_ll;
    endcase
  end

  logic signed [11:0] factor;
  assign factor = lvl_r[1] ? (12'sd1000 + $signed({2'b00, hyst}))
                           : (12'sd1000 - $signed({2'b00, hyst}));

  logic keep_cp;
  assign keep_cp = used_r[idx_r] && (active_r[idx_r] || !acked_r[idx_r]);

  logic [RecAw-1:0] next_en_lvl;
  logic has_next_lvl;
  always_comb begin
    has_next_lvl = 1'b0;
    next_en_lvl = '0;
    for (int i = 3; i >= 0; i--) begin
      if (32'(i) > 32'(lvl_r) && level_enable[3-i]) begin
        has_next_lvl = 1'b1;
        next_en_lvl = RecAw'(i);
      end
    end
  end

  logic [3:0] lvl_bit;
  assign lvl_bit = 4'b1000 >> lvl_r;

  logic fire_c, clr_c;
  assign fire_c = (level_active_r & lvl_bit) == 4'd0 && (lvl_r[1] ? lim_lt_r : lim_gt_r);
  assign clr_c = (level_active_r & lvl_bit) != 4'd0 &&
                 (lvl_r[1] ? (lhs_r > rhs_r) : (lhs_r < rhs_r));

  logic [RecDepth-1:0] fill_mask, fill_bit;
  always_comb begin
    for (int i = 0; i < RecDepth; i++) begin
      fill_mask[i] = (5'(i) < fill_r);
      fill_bit[i] = (5'(i) == fill_r);
    end
  end

  assign mem_raddr = idx_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = dst_r;
    mem_wdata = mem_rdata;
    if (state_r == S_CPWRITE && keep_cp) begin
      mem_we = 1'b1;
    end else if (state_r == S_FIRE) begin
      mem_we = (fill_r != 5'(RecDepth));
      mem_waddr = fill_r[RecAw-1:0];
      mem_wdata.level = lvl_r;
      mem_wdata.ident = next_ident_r;
      mem_wdata.value = in_r.sample;
    end
  end

  function automatic out_word_t mk(input logic [1:0] k, input logic [1:0] l,
                                   input logic [15:0] id,
                                   input logic [ValueBits-1:0] v,
                                   input logic [CntBits-1:0] ac,
                                   input logic [CntBits-1:0] uc, input logic o,
                                   input logic ls);
    out_word_t w;
    w.kind = k; w.alarm_level = l; w.record_id = id; w.value = v;
    w.active_count = ac; w.unacked_count = uc; w.overflow = o; w.last = ls;
    return w;
  endfunction

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_active_r <= '0;
      used_r <= '0; active_r <= '0; acked_r <= '0;
      next_ident_r <= '0;
      active_total_r <= '0; unacked_total_r <= '0;
      idx_r <= '0; dst_r <= '0; fill_r <= '0;
      lvl_r <= '0; scan_mode_r <= SCAN_CLEAR; ack_hit_r <= 1'b0;
      pend_r <= 1'b0; pend_ovf_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r <= in_word;
            idx_r <= '0;
            if (in_word.cmd == CMD_EVAL) begin
              if (in_word.point_id == watched_point && level_enable != 4'd0) begin
                lvl_r <= level_enable[3] ? 2'd0 : level_enable[2] ? 2'd1 :
                         level_enable[1] ? 2'd2 : 2'd3;
                state_r <= S_LEVEL;
              end else begin
                state_r <= S_IDLE;
              end
            end else if (in_word.cmd == CMD_ACK_ONE || in_word.cmd == CMD_ACK_ALL) begin
              scan_mode_r <= (in_word.cmd == CMD_ACK_ONE) ? SCAN_ACK1 : SCAN_ACKALL;
              ack_hit_r <= 1'b0;
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_LEVEL: begin
          lhs_r <= (ValueBits+11)'(in_r.sample) * (ValueBits+11)'(11'sd1000);
          rhs_r <= (ValueBits+11)'(lim_sel) * (ValueBits+11)'(factor);
          lim_gt_r <= in_r.sample > lim_sel;
          lim_lt_r <= in_r.sample < lim_sel;
          state_r <= S_MUL;
        end
        S_MUL: state_r <= S_CMP;
        S_CMP: begin
          idx_r <= '0;
          dst_r <= '0;
          if (fire_c || clr_c) begin
            if (pend_r) begin
              out_valid <= 1'b1;
              out_word <= mk(KIND_SUMMARY, 2'd0, 16'd0, '0, active_total_r,
                             unacked_total_r, pend_ovf_r, 1'b0);
            end
            pend_r <= 1'b0;
            if (fire_c) begin
              state_r <= S_CPREAD;
            end else begin
              scan_mode_r <= SCAN_CLEAR;
              state_r <= S_SCAN_RD;
            end
          end else if (has_next_lvl) begin
            lvl_r <= next_en_lvl[1:0];
            state_r <= S_LEVEL;
          end else begin
            if (pend_r) begin
              out_valid <= 1'b1;
              out_word <= mk(KIND_SUMMARY, 2'd0, 16'd0, '0, active_total_r,
                             unacked_total_r, pend_ovf_r, 1'b1);
            end
            pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_CPREAD: state_r <= S_CPWRITE;
        S_CPWRITE: begin
          if (keep_cp) begin
            active_r[dst_r] <= active_r[idx_r];
            acked_r[dst_r] <= acked_r[idx_r];
            dst_r <= dst_r + 1'b1;
          end
          if (idx_r == RecAw'(RecDepth-1)) begin
            fill_r <= 5'(dst_r) + 5'(keep_cp);
            state_r <= S_FIRE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_CPREAD;
          end
        end
        S_FIRE: begin
          used_r <= (used_r & fill_mask) | fill_bit;
          active_r <= (active_r & fill_mask) | fill_bit;
          acked_r <= acked_r & fill_mask;
          if (fill_r == 5'(RecDepth)) begin
            if (has_next_lvl) begin
              pend_r <= 1'b1;
              pend_ovf_r <= 1'b1;
              lvl_r <= next_en_lvl[1:0];
              state_r <= S_LEVEL;
            end else begin
              out_valid <= 1'b1;
              out_word <= mk(KIND_SUMMARY, 2'd0, 16'd0, '0, active_total_r,
                             unacked_total_r, 1'b1, 1'b1);
              state_r <= S_IDLE;
            end
          end else begin
            next_ident_r <= next_ident_r + 16'd1;
            active_total_r <= active_total_r + 1'b1;
            unacked_total_r <= unacked_total_r + 1'b1;
            level_active_r <= level_active_r | lvl_bit;
            out_valid <= 1'b1;
            out_word <= mk(KIND_TRIG, lvl_r, next_ident_r, in_r.sample,
                           active_total_r + 1'b1, unacked_total_r + 1'b1, 1'b0, 1'b0);
            state_r <= S_SUMMARY;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_EMIT;
        S_SCAN_EMIT: begin
          if (scan_mode_r == SCAN_CLEAR) begin
            if (used_r[idx_r] && active_r[idx_r] && mem_rdata.level == lvl_r) begin
              active_r[idx_r] <= 1'b0;
              if (active_total_r != '0) active_total_r <= active_total_r - 1'b1;
              out_valid <= 1'b1;
              out_word <= mk(KIND_CLEAR, lvl_r, mem_rdata.ident, '0,
                             (active_total_r != '0) ? active_total_r - 1'b1 : '0,
                             unacked_total_r, 1'b0, 1'b0);
            end
          end else if (used_r[idx_r] && !acked_r[idx_r] &&
                       (scan_mode_r == SCAN_ACKALL ||
                        (!ack_hit_r && mem_rdata.ident == in_r.ack_id))) begin
            acked_r[idx_r] <= 1'b1;
            ack_hit_r <= 1'b1;
            if (unacked_total_r != '0) unacked_total_r <= unacked_total_r - 1'b1;
            out_valid <= 1'b1;
            out_word <= mk(KIND_ACK, mem_rdata.level, mem_rdata.ident, '0,
                           active_total_r,
                           (unacked_total_r != '0) ? unacked_total_r - 1'b1 : '0,
                           1'b0, 1'b0);
          end
          if (idx_r == RecAw'(RecDepth-1)) begin
            state_r <= S_SUMMARY;
            if (scan_mode_r == SCAN_CLEAR) begin
              level_active_r <= level_active_r & ~lvl_bit;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SCAN_RD;
          end
        end
        S_SUMMARY: begin
          idx_r <= '0;
          dst_r <= '0;
          if (in_r.cmd == CMD_EVAL && has_next_lvl) begin
            pend_r <= 1'b1;
            pend_ovf_r <= 1'b0;
            lvl_r <= next_en_lvl[1:0];
            state_r <= S_LEVEL;
          end else begin
            out_valid <= 1'b1;
            out_word <= mk(KIND_SUMMARY, 2'd0, 16'd0, '0, active_total_r,
                           unacked_total_r, 1'b0, 1'b1);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/pla_checker.sv
// Port checker for the process level alarm.
// Depends on pla_pkg; bound to the top level.
`timescale 1ns / 1ps
module pla_checker
  import pla_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_word_t out_word
);
  a_no_out_in_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("word during reset");
  a_quiet_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_strobe)
    else $error("word right after start");
  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.kind == KIND_SUMMARY |-> out_word.record_id == 16'd0)
    else $error("summary id");
  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.last |-> out_word.kind == KIND_SUMMARY)
    else $error("last on non-summary");
  a_value_trig_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.kind != KIND_TRIG |-> out_word.value == '0)
    else $error("value on non-trigger");
endmodule

bind process_level_alarm_with_ack pla_checker u_pla_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_word(out_word)
);
